// ----- hdl/edb_pkg.sv -----
// Shared types and defaults for the evicting bounded deque.
// Used by edb_cell and evicting_bounded_deque; depends on nothing else.
package edb_pkg;

  localparam int unsigned DefaultDepth      = 16;
  localparam int unsigned DefaultValueWidth = 32;

  // Operation carried in the input tuser.
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  // Kind of return carried in the output tuser.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_EVICT = 2'd2
  } kind_e;

  // What every cell of the row does at each clock edge.
  typedef enum logic [2:0] {
    MODE_HOLD,
    MODE_PUSH_FRONT,    // take the left neighbour; the first cell takes the new word
    MODE_APPEND,        // the cell at the count takes the new word
    MODE_EVICT_APPEND,  // take the right neighbour; the cell at count-1 takes the word
    MODE_POP_FRONT      // take the right neighbour
  } mode_e;

endpackage

// ----- hdl/evicting_bounded_deque.sv -----
// The result of an accepted item is held in the output register from the next cycle on.
// Throughput: one item per cycle; the row of cells updates as each item is accepted,
// and a new item is taken whenever the output register is empty or being drained.
// Reset clears the entry count, the capacity limit and the output valid; the cell
// contents are not cleared, as only entries that were written are ever returned.
module evicting_bounded_deque #(
  parameter int unsigned DEPTH       = edb_pkg::DefaultDepth,
  parameter int unsigned VALUE_WIDTH = edb_pkg::DefaultValueWidth,
  localparam int unsigned COUNT_W    = $clog2(DEPTH + 1),
  localparam int unsigned IN_W       = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((VALUE_WIDTH + COUNT_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [COUNT_W-1:0] cfg_wdata_i,   // capacity_limit
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,  // push_value
  input  logic [1:0]         s_axis_tuser,  // operation
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata,  // returned_value, entry_count
  output logic [1:0]         m_axis_tuser   // return_kind
);
  import edb_pkg::*;

  logic [COUNT_W-1:0]     limit_q;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [COUNT_W-1:0]     eff_limit;
  logic                   in_fire, evict;
  op_e                    op;
  mode_e                  mode;
  logic [VALUE_WIDTH-1:0] word;
  logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_tail [DEPTH];
  logic [VALUE_WIDTH-1:0] tail_value;
  logic [VALUE_WIDTH-1:0] ret_d, ret_q;
  kind_e                  kind_d, kind_q;
  logic                   out_valid_q;
  logic [COUNT_W-1:0]     out_count_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign word          = s_axis_tdata[VALUE_WIDTH-1:0];

  // A limit of zero or beyond the store size means the whole store.
  assign eff_limit = (limit_q == '0 || limit_q > COUNT_W'(DEPTH)) ? COUNT_W'(DEPTH) : limit_q;
  assign evict     = (count_q >= eff_limit) && (count_q != '0);

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_value = tail_value | cell_tail[i];
    end
  end

  always_comb begin
    mode    = MODE_HOLD;
    count_d = count_q;
    ret_d   = '0;
    kind_d  = KIND_NONE;
    if (in_fire) begin
      case (op)
        OP_PUSH_FRONT: begin
          mode = MODE_PUSH_FRONT;
          if (evict) begin
            ret_d  = tail_value;
            kind_d = KIND_EVICT;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        OP_PUSH_BACK: begin
          if (evict) begin
            mode   = MODE_EVICT_APPEND;
            ret_d  = cell_data[0];
            kind_d = KIND_EVICT;
          end else begin
            mode    = MODE_APPEND;
            count_d = count_q + 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (count_q != '0) begin
            mode    = MODE_POP_FRONT;
            ret_d   = cell_data[0];
            kind_d  = KIND_POP;
            count_d = count_q - 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (count_q != '0) begin
            ret_d   = tail_value;
            kind_d  = KIND_POP;
            count_d = count_q - 1'b1;
          end
        end
        default: begin
          mode = MODE_HOLD;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = word;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    edb_cell #(
      .INDEX      (g),
      .VALUE_WIDTH(VALUE_WIDTH),
      .COUNT_W    (COUNT_W)
    ) u_cell (
      .clk_i  (clk_i),
      .mode_i (mode),
      .count_i(count_q),
      .word_i (word),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g]),
      .tail_o (cell_tail[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ret_q       <= ret_d;
      kind_q      <= kind_d;
      out_count_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'({out_count_q, ret_q});
  assign m_axis_tuser  = kind_q;

endmodule

// ----- hdl/edb_cell.sv -----
// One storage cell of the deque row: holds one entry, shifts to either neighbour.
// Depends on edb_pkg for the row mode.
module edb_cell #(
  parameter int unsigned INDEX       = 0,
  parameter int unsigned VALUE_WIDTH = edb_pkg::DefaultValueWidth,
  parameter int unsigned COUNT_W     = 5
) (
  input  logic                   clk_i,
  input  edb_pkg::mode_e         mode_i,
  input  logic [COUNT_W-1:0]     count_i,
  input  logic [VALUE_WIDTH-1:0] word_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  output logic [VALUE_WIDTH-1:0] data_o,
  output logic [VALUE_WIDTH-1:0] tail_o
);
  import edb_pkg::*;

  logic [VALUE_WIDTH-1:0] data_q, data_d;
  logic                   at_count, at_tail;

  assign at_count = (count_i == COUNT_W'(INDEX));
  assign at_tail  = (count_i == COUNT_W'(INDEX + 1));

  always_comb begin
    data_d = data_q;
    case (mode_i)
      MODE_PUSH_FRONT:   data_d = left_i;
      MODE_APPEND:       data_d = at_count ? word_i : data_q;
      MODE_EVICT_APPEND: data_d = at_tail ? word_i : right_i;
      MODE_POP_FRONT:    data_d = right_i;
      default:           data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Only the last occupied cell offers its entry to the back-end read.
  assign tail_o = at_tail ? data_q : '0;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the evicting bounded deque (top level evicting_bounded_deque).
// Depends on edb_pkg for the operation and return kind codes; needs nothing but the RTL.
`timescale 1ns / 1ps

module testbench;
  import edb_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned CountW      = 5;
  localparam int unsigned OutW        = 40;
  localparam int unsigned IdleLimit   = 5000;
  localparam int unsigned HoldAt      = 500;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned PhaseItems  = 180;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    op_e         op;
    logic [31:0] word;
  } deque_cmd_t;

  typedef struct packed {
    logic [31:0]       value;
    kind_e             kind;
    logic [CountW-1:0] count;
  } deque_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [CountW-1:0] cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;
  logic [1:0]        s_axis_tuser  = 2'b00;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutW-1:0]   m_axis_tdata;
  logic [1:0]        m_axis_tuser;

  evicting_bounded_deque u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  deque_cmd_t    pending_cmds[$];
  deque_result_t expected_results[$];

  // Shadow copy of the deque: ring of entries, front index, count and limit.
  logic [31:0]       shadow_ring [DEPTH];
  logic [3:0]        shadow_front = '0;
  logic [CountW-1:0] shadow_count = '0;
  logic [CountW-1:0] shadow_limit = '0;

  int unsigned accepted_items = 0;
  int unsigned checked_items  = 0;
  int unsigned fail_count     = 0;
  int unsigned pops_seen      = 0;
  int unsigned evicts_seen    = 0;
  int unsigned full_seen      = 0;
  int unsigned limit_writes   = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_left      = 0;
  logic        hold_done      = 1'b0;

  int send_gap  = 0;
  int send_run  = 0;
  int recv_gap  = 0;
  int recv_run  = 0;

  // Mostly short gaps, a few long ones, and now and then a run with no gaps at all.
  function automatic int pick_gap(inout int run_left);
    int r;
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      run_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CountW-1:0] effective_limit();
    if (shadow_limit == 0 || shadow_limit > DEPTH) return CountW'(DEPTH);
    return shadow_limit;
  endfunction

  task automatic predict_deque_op(input op_e op, input logic [31:0] word);
    deque_result_t res;
    logic [3:0]    at;
    res.value = '0;
    res.kind  = KIND_NONE;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      // At the limit the entry at the opposite end goes out first.
      if (shadow_count >= effective_limit() && shadow_count > 0) begin
        res.kind = KIND_EVICT;
        if (op == OP_PUSH_FRONT) begin
          at = shadow_front + shadow_count[3:0] - 4'd1;
          res.value = shadow_ring[at];
        end else begin
          res.value = shadow_ring[shadow_front];
          shadow_front = shadow_front + 4'd1;
        end
        shadow_count = shadow_count - 1'b1;
      end
      if (op == OP_PUSH_FRONT) begin
        shadow_front = shadow_front - 4'd1;
        shadow_ring[shadow_front] = word;
      end else begin
        at = shadow_front + shadow_count[3:0];
        shadow_ring[at] = word;
      end
      shadow_count = shadow_count + 1'b1;
    end else if (shadow_count > 0) begin
      res.kind = KIND_POP;
      if (op == OP_POP_FRONT) begin
        res.value = shadow_ring[shadow_front];
        shadow_front = shadow_front + 4'd1;
      end else begin
        at = shadow_front + shadow_count[3:0] - 4'd1;
        res.value = shadow_ring[at];
      end
      shadow_count = shadow_count - 1'b1;
    end
    res.count = shadow_count;
    expected_results.push_back(res);
  endtask

  // Driver: offers pending items and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    logic       busy;
    deque_cmd_t cmd;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_deque_op(op_e'(s_axis_tuser), s_axis_tdata);
        accepted_items <= accepted_items + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd = pending_cmds[0];
          pending_cmds.delete(0);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cmd.op;
          s_axis_tdata  <= cmd.word;
          send_gap = pick_gap(send_run);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // One long hold-off on the result side while the sender keeps offering items.
  always @(posedge clk_i) begin
    if (!hold_done && accepted_items >= HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      recv_gap = pick_gap(recv_run);
    end
  end

  // Monitor: every accepted result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    deque_result_t want;
    logic [31:0]   got_value;
    logic [CountW-1:0] got_count;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_value = m_axis_tdata[31:0];
      got_count = m_axis_tdata[32 +: CountW];
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("ERROR: result with nothing expected: value %h kind %0d count %0d",
                   got_value, m_axis_tuser, got_count);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got_value !== want.value || m_axis_tuser !== want.kind ||
            got_count !== want.count) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("ERROR: result %0d: expected value %h kind %0d count %0d",
                     checked_items, want.value, want.kind, want.count);
            $display("       got value %h kind %0d count %0d",
                     got_value, m_axis_tuser, got_count);
          end
        end
        if (want.kind == KIND_POP) pops_seen++;
        if (want.kind == KIND_EVICT) evicts_seen++;
        if (want.count == DEPTH) full_seen++;
      end
      checked_items++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no item moved for %0d cycles", IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic drain_results();
    while (pending_cmds.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CountW-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_limit = value;
    limit_writes++;
  endtask

  task automatic queue_cmd(input op_e op, input logic [31:0] word);
    deque_cmd_t cmd;
    cmd.op   = op;
    cmd.word = word;
    pending_cmds.push_back(cmd);
  endtask

  // Random phase: the push share changes every few dozen items, so the deque
  // swings between empty and full at every limit.
  task automatic queue_random(input int unsigned n);
    int unsigned push_pct;
    logic        is_push;
    op_e         op;
    logic [31:0] word;
    push_pct = 50;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 25;
          1: push_pct = 50;
          2: push_pct = 75;
          default: push_pct = 92;
        endcase
      end
      is_push = ($urandom_range(0, 99) < push_pct);
      if (is_push) op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      case ($urandom_range(0, 15))
        0: word = '0;
        1: word = '1;
        default: word = $urandom();
      endcase
      queue_cmd(op, word);
    end
  endtask

  initial begin
    logic [CountW-1:0] limits [9];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pops on an empty deque, extreme words at both ends, pops in both directions.
    write_limit(5'd0);
    queue_cmd(OP_POP_FRONT, 32'hFFFF_FFFF);
    queue_cmd(OP_POP_BACK, 32'h0000_0000);
    queue_cmd(OP_PUSH_BACK, 32'h0000_0000);
    queue_cmd(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    queue_cmd(OP_PUSH_BACK, 32'hA5A5_A5A5);
    queue_cmd(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    queue_cmd(OP_POP_FRONT, 32'h0);
    queue_cmd(OP_POP_BACK, 32'h0);
    queue_cmd(OP_POP_BACK, 32'h0);
    queue_cmd(OP_POP_FRONT, 32'h0);
    queue_cmd(OP_POP_BACK, 32'h0);

    // Directed: evictions at a small limit, then the limit lowered below the count.
    write_limit(5'd3);
    queue_cmd(OP_PUSH_BACK, 32'h1111_1111);
    queue_cmd(OP_PUSH_BACK, 32'h2222_2222);
    queue_cmd(OP_PUSH_BACK, 32'h3333_3333);
    queue_cmd(OP_PUSH_BACK, 32'h4444_4444);
    queue_cmd(OP_PUSH_FRONT, 32'h5555_5555);
    write_limit(5'd1);
    queue_cmd(OP_PUSH_BACK, 32'h6666_6666);
    queue_cmd(OP_PUSH_FRONT, 32'h7777_7777);
    queue_cmd(OP_POP_FRONT, 32'h0);
    queue_cmd(OP_POP_BACK, 32'h0);
    queue_cmd(OP_POP_BACK, 32'h0);
    queue_cmd(OP_POP_FRONT, 32'h0);

    limits[0] = 5'd0;
    limits[1] = 5'd16;
    limits[2] = 5'd31;
    limits[3] = 5'd1;
    limits[4] = 5'd2;
    limits[5] = 5'd17;
    limits[6] = 5'd5;
    limits[7] = CountW'($urandom_range(3, 15));
    limits[8] = CountW'($urandom_range(0, 31));
    foreach (limits[i]) begin
      write_limit(limits[i]);
      queue_random(PhaseItems);
    end

    drain_results();
    $display("Checked %0d results over %0d limit settings.", checked_items, limit_writes);
    $display("Seen %0d pops, %0d evictions and %0d results at full depth.",
             pops_seen, evicts_seen, full_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
